[rtl/itsc_pkg.sv]
// shared types and constants of the id tagged slot cache
// entry layout, opcode and status codes, field widths
// no dependencies
package itsc_pkg;

	localparam int SLOTS_DEF = 256;

	localparam int ID_W     = 32;
	localparam int HANDLE_W = 32;
	localparam int LEN_W    = 16;

	// beat widths on both sides
	localparam int DATA_W   = 112;
	localparam int S_USER_W = 2;
	localparam int M_USER_W = 3;

	// ids run from first to last and then start over
	localparam logic [ID_W-1:0] ID_FIRST = 32'd1;
	localparam logic [ID_W-1:0] ID_LAST  = 32'hFFFF_FFFE;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_RETRIEVE = 2'd1,
		OP_GET      = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_INVALID   = 2'd2
	} status_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic                valid;
		logic [ID_W-1:0]     tag;
		logic [HANDLE_W-1:0] info;
		logic [HANDLE_W-1:0] packet;
		logic [LEN_W-1:0]    length;
	} entry_t;

endpackage

[rtl/itsc_slot_mod.sv]
// id to slot index: id mod SLOTS in three pipeline stages
// power-of-two table sizes use a mask, others a reciprocal multiply
// depends on itsc_pkg
module itsc_slot_mod #(
	parameter int SLOTS = itsc_pkg::SLOTS_DEF,
	parameter int IDX_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [itsc_pkg::ID_W-1:0] id,
	output logic                      done,
	output logic [IDX_W-1:0]          idx
);
	import itsc_pkg::*;

	localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

	logic v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] idx_s3;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	generate
		if (POW2) begin : g_mask
			logic [ID_W-1:0] x_s1, x_s2;

			// low bits carry the slot directly
			always_ff @(posedge clk) begin
				x_s1   <= id;
				x_s2   <= x_s1;
				idx_s3 <= IDX_W'(x_s2 & ID_W'(SLOTS - 1));
			end
		end else begin : g_recip
			localparam logic [ID_W-1:0] RECIP   = ID_W'((64'd1 << 32) / SLOTS);
			localparam logic [ID_W-1:0] SLOTS_W = ID_W'(SLOTS);

			logic [2*ID_W-1:0] prod;
			logic [ID_W-1:0]   x_s1, x_s2, q_s1, qs_s2, qs;
			logic [ID_W-1:0]   rem, rem_fix;

			// quotient estimate, at most one short of the true quotient
			assign prod = {{ID_W{1'b0}}, id} * {{ID_W{1'b0}}, RECIP};
			assign qs   = q_s1 * SLOTS_W;

			// remainder below twice the table size, one correction step
			assign rem     = x_s2 - qs_s2;
			assign rem_fix = (rem >= SLOTS_W) ? rem - SLOTS_W : rem;

			always_ff @(posedge clk) begin
				x_s1   <= id;
				q_s1   <= prod[2*ID_W-1:ID_W];
				x_s2   <= x_s1;
				qs_s2  <= qs;
				idx_s3 <= IDX_W'(rem_fix);
			end
		end
	endgenerate

	assign done = v_s3;
	assign idx  = idx_s3;

endmodule

[rtl/itsc_slot_ram.sv]
// slot memory: one write port, one read port with registered read data
// holds the valid bit, tag and handles of each slot
// depends on itsc_pkg
module itsc_slot_ram #(
	parameter int DEPTH  = itsc_pkg::SLOTS_DEF,
	parameter int ADDR_W = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [ADDR_W-1:0]        wr_addr,
	input  itsc_pkg::entry_t         wr_data,
	input  logic                     rd_en,
	input  logic [ADDR_W-1:0]        rd_addr,
	output itsc_pkg::entry_t         rd_data
);
	import itsc_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data in the cycle after the read and held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[rtl/id_tagged_slot_cache.sv]
// id tagged slot cache: one request at a time; a request passes the id mod SLOTS
// pipeline, one slot memory read and a check and write back step, and the next
// input beat is taken only once the result is registered
// after reset a clearing pass writes every slot empty, with s_tready low
// throughout; the id counter restarts at 1
module id_tagged_slot_cache #(
	parameter int SLOTS = itsc_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// query_id[31:0], info_handle[63:32], packet_handle[95:64],
	// packet_length[111:96]
	input  logic [itsc_pkg::DATA_W-1:0]   s_tdata,
	// opcode[1:0]
	input  logic [itsc_pkg::S_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// assigned_id[31:0], out_info[63:32], out_packet[95:64],
	// out_length[111:96]
	output logic [itsc_pkg::DATA_W-1:0]   m_tdata,
	// status[1:0], evicted[2]
	output logic [itsc_pkg::M_USER_W-1:0] m_tuser
);
	import itsc_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_MOD   = 4'b0100,
		S_EXEC  = 4'b1000
	} state_t;

	state_t state_q;

	logic [IDX_W-1:0]    clr_q, idx_q, mod_idx;
	logic [ID_W-1:0]     next_id_q, id_q, start_id;
	logic [1:0]          op_q;
	logic [HANDLE_W-1:0] info_q, packet_q;
	logic [LEN_W-1:0]    len_q;
	logic                in_beat, mod_start, mod_done, out_free, exec_go;

	entry_t              ent, wr_entry, ram_wdata;
	logic                ram_we, ram_re;
	logic [IDX_W-1:0]    ram_waddr;

	logic                mem_write, bump, hit;
	status_t             res_status;
	logic [ID_W-1:0]     res_assigned;
	logic                res_evicted;
	logic [HANDLE_W-1:0] res_info, res_packet;
	logic [LEN_W-1:0]    res_length;

	logic                         m_tvalid_q;
	logic [DATA_W-1:0]            m_tdata_q;
	logic [M_USER_W-1:0]          m_tuser_q;

	// handshake
	assign s_tready  = (state_q == S_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign exec_go   = (state_q == S_EXEC) && out_free;

	// register requests map the counter, lookups map the query
	assign mod_start = in_beat;
	assign start_id  = (s_tuser == OP_REGISTER) ? next_id_q : s_tdata[ID_W-1:0];

	itsc_slot_mod #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.id     (start_id),
		.done   (mod_done),
		.idx    (mod_idx)
	);

	// memory port steering: clearing pass or write back
	assign ram_re    = (state_q == S_MOD) && mod_done;
	assign ram_we    = (state_q == S_CLEAR) || (exec_go && mem_write);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : wr_entry;

	itsc_slot_ram #(
		.DEPTH  (SLOTS),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (mod_idx),
		.rd_data (ent)
	);

	assign hit = (id_q != '0) && ent.valid && (ent.tag == id_q);

	// check the slot, form the result and the write back
	always_comb begin
		res_status   = ST_NOT_FOUND;
		res_assigned = '0;
		res_evicted  = 1'b0;
		res_info     = '0;
		res_packet   = '0;
		res_length   = '0;
		mem_write    = 1'b0;
		bump         = 1'b0;
		wr_entry     = ent;
		case (op_q)
			OP_REGISTER: begin
				if (info_q == '0 || packet_q == '0) begin
					res_status = ST_INVALID;
				end else begin
					res_status   = ST_OK;
					res_assigned = id_q;
					res_evicted  = ent.valid;
					if (ent.valid) begin
						res_info   = ent.info;
						res_packet = ent.packet;
					end
					mem_write       = 1'b1;
					bump            = 1'b1;
					wr_entry.valid  = 1'b1;
					wr_entry.tag    = id_q;
					wr_entry.info   = info_q;
					wr_entry.packet = packet_q;
					wr_entry.length = len_q;
				end
			end
			OP_RETRIEVE, OP_GET: begin
				if (hit) begin
					res_status = ST_OK;
					res_packet = ent.packet;
					res_length = ent.length;
					if (op_q == OP_RETRIEVE) begin
						res_info       = ent.info;
						mem_write      = 1'b1;
						wr_entry.valid = 1'b0;
					end
				end
			end
			default: begin
				res_status = ST_NOT_FOUND;
			end
		endcase
	end

	// sequencer, clearing counter and id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			next_id_q <= ID_FIRST;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (bump) begin
							next_id_q <= (next_id_q == ID_LAST) ? ID_FIRST
								: next_id_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request fields held for the duration of the request
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q     <= s_tuser;
			id_q     <= start_id;
			info_q   <= s_tdata[ID_W +: HANDLE_W];
			packet_q <= s_tdata[ID_W + HANDLE_W +: HANDLE_W];
			len_q    <= s_tdata[ID_W + 2*HANDLE_W +: LEN_W];
		end
		if (ram_re) begin
			idx_q <= mod_idx;
		end
	end

	// result register, freed by the downstream beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			m_tdata_q <= {res_length, res_packet, res_info, res_assigned};
			m_tuser_q <= {res_evicted, res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[rtl/itsc_checker.sv]
// port level checks of the id tagged slot cache, bound to the top level
// depends on itsc_pkg and id_tagged_slot_cache
module itsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [itsc_pkg::DATA_W-1:0]   m_tdata,
	input logic [itsc_pkg::M_USER_W-1:0] m_tuser
);
	import itsc_pkg::*;

	// one request in flight: no second beat right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a request is in flight");

	// a stalled result beat holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed under back pressure");

	// failed requests carry an empty payload
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != ST_OK) |-> (m_tdata == '0) && !m_tuser[2])
		else $error("failed request returned data");

	// an eviction only comes with a successful register, a fresh id and nonzero handles
	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == ST_OK) && (m_tdata[31:0] != '0)
			&& (m_tdata[95:64] != '0) && (m_tdata[63:32] != '0))
		else $error("eviction without a valid register result");

endmodule

bind id_tagged_slot_cache itsc_checker u_itsc_checker (.*);

[tb/id_tagged_slot_cache_tb.sv]
// testbench for the id tagged slot cache: directed and random register, retrieve and get
// beats, with the replies checked field by field against a predicted slot table
// depends on itsc_pkg and id_tagged_slot_cache
module id_tagged_slot_cache_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import itsc_pkg::*;

	localparam int SLOTS          = SLOTS_DEF;
	localparam int RANDOM_ITEMS   = 880;
	localparam int CALM_FROM      = 200;
	localparam int CALM_TO        = 350;
	localparam int HOLD_AT        = 600;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 3000;

	// opcode that the block answers with not found and otherwise ignores
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// predicted slot table and the replies still owed by the block
	class slot_table_scoreboard;
		typedef struct packed {
			status_t             status;
			logic [ID_W-1:0]     assigned_id;
			logic                evicted;
			logic [HANDLE_W-1:0] info;
			logic [HANDLE_W-1:0] packet;
			logic [LEN_W-1:0]    length;
		} reply_t;

		logic [ID_W-1:0]     next_id = ID_FIRST;
		bit                  slot_valid [SLOTS];
		logic [ID_W-1:0]     slot_tag [SLOTS];
		logic [HANDLE_W-1:0] slot_info [SLOTS];
		logic [HANDLE_W-1:0] slot_packet [SLOTS];
		logic [LEN_W-1:0]    slot_length [SLOTS];
		reply_t              pending_replies [$];
		int                  errors = 0;

		// update the table for one accepted request and queue the reply it owes
		function void log_request(logic [1:0] op, logic [ID_W-1:0] query,
				logic [HANDLE_W-1:0] info, logic [HANDLE_W-1:0] packet,
				logic [LEN_W-1:0] length);
			reply_t      r;
			int unsigned s;
			r = '0;
			r.status = ST_NOT_FOUND;
			case (op)
				OP_REGISTER: begin
					if (info == '0 || packet == '0) begin
						r.status = ST_INVALID;
					end else begin
						s = next_id % SLOTS;
						if (slot_valid[s]) begin
							r.evicted = 1'b1;
							r.info    = slot_info[s];
							r.packet  = slot_packet[s];
						end
						slot_valid[s]  = 1'b1;
						slot_tag[s]    = next_id;
						slot_info[s]   = info;
						slot_packet[s] = packet;
						slot_length[s] = length;
						r.status       = ST_OK;
						r.assigned_id  = next_id;
						next_id = (next_id == ID_LAST) ? ID_FIRST : next_id + 1;
					end
				end
				OP_RETRIEVE, OP_GET: begin
					s = query % SLOTS;
					if (query != '0 && slot_valid[s] && slot_tag[s] == query) begin
						r.status = ST_OK;
						r.packet = slot_packet[s];
						r.length = slot_length[s];
						// get leaves the entry and reports no info handle
						if (op == OP_RETRIEVE) begin
							r.info        = slot_info[s];
							slot_valid[s] = 1'b0;
						end
					end
				end
				default: ;
			endcase
			pending_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		// compare one reply beat with the oldest owed reply
		function void check_reply(logic [DATA_W-1:0] data, logic [M_USER_W-1:0] user);
			reply_t want;
			if (pending_replies.size() == 0) begin
				$error("reply beat with no request outstanding");
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			compare_field("status", 32'(want.status), 32'(user[1:0]));
			compare_field("evicted", 32'(want.evicted), 32'(user[2]));
			compare_field("assigned_id", want.assigned_id, data[31:0]);
			compare_field("out_info", want.info, data[63:32]);
			compare_field("out_packet", want.packet, data[95:64]);
			compare_field("out_length", 32'(want.length), 32'(data[111:96]));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata;   // query_id, info_handle, packet_handle, packet_length
	logic [S_USER_W-1:0]   s_tuser;   // opcode
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DATA_W-1:0]     m_tdata;   // assigned_id, out_info, out_packet, out_length
	logic [M_USER_W-1:0]   m_tuser;   // status, evicted

	slot_table_scoreboard sb = new;
	bit                   calm_stretch = 1'b0;
	bit                   hold_done = 1'b0;
	int                   beats_in = 0;
	int                   quiet_cycles = 0;

	id_tagged_slot_cache #(.SLOTS(SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// beat monitor and watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.log_request(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
				s_tdata[111:96]);
			beats_in++;
		end
		if (arst_n && m_tvalid && m_tready)
			sb.check_reply(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off after HOLD_AT accepted beats
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && beats_in >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm_stretch || ($urandom_range(99) >= 23);
			end
		end
	end

	// offer one request beat and wait for it to be taken
	task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] query,
			input logic [HANDLE_W-1:0] info, input logic [HANDLE_W-1:0] packet,
			input logic [LEN_W-1:0] length);
		while (!calm_stretch && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {length, packet, info, query};
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin : stimulus
		logic [1:0]          op;
		logic [ID_W-1:0]     query;
		logic [ID_W-1:0]     newest;
		logic [HANDLE_W-1:0] info;
		logic [HANDLE_W-1:0] packet;
		logic [LEN_W-1:0]    length;
		int                  roll;
		int                  pick;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_REGISTER;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lookup on an empty table, then the null handle cases
		send_request(OP_GET, 32'd1, $urandom, $urandom, 16'hFFFF);
		send_request(OP_REGISTER, ID_LAST, 32'd0, 32'd5, 16'd7);
		send_request(OP_REGISTER, 32'd0, 32'd5, 32'd0, 16'hFFFF);
		send_request(OP_REGISTER, 32'd0, 32'd0, 32'd0, 16'd0);
		// extreme handles and lengths, ids 1 and 2
		send_request(OP_REGISTER, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_REGISTER, 32'd0, 32'd1, 32'd1, 16'd0);
		// hit, id zero, tag mismatch in an occupied slot
		send_request(OP_GET, 32'd1, 32'd0, 32'd0, 16'd0);
		send_request(OP_GET, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_GET, 32'd1 + SLOTS, 32'd0, 32'd0, 16'd0);
		send_request(OP_RETRIEVE, 32'd1 + SLOTS, 32'd0, 32'd0, 16'd0);
		// retrieve removes the entry, so the repeats miss
		send_request(OP_RETRIEVE, 32'd1, 32'd0, 32'd0, 16'd0);
		send_request(OP_RETRIEVE, 32'd1, 32'd0, 32'd0, 16'd0);
		send_request(OP_GET, 32'd1, 32'd0, 32'd0, 16'd0);
		send_request(OP_UNUSED, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_RETRIEVE, ID_LAST, 32'd0, 32'd0, 16'd0);
		send_request(OP_GET, 32'd2, 32'd0, 32'd0, 16'd0);
		send_request(OP_RETRIEVE, 32'd2, 32'd0, 32'd0, 16'd0);
		send_request(OP_GET, 32'd2, 32'd0, 32'd0, 16'd0);
		send_request(OP_RETRIEVE, 32'd0, 32'd0, 32'd0, 16'd0);

		// random mix, mostly registers and lookups of recent ids
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm_stretch = (n >= CALM_FROM && n < CALM_TO);
			roll   = $urandom_range(99);
			info   = $urandom;
			packet = $urandom;
			length = LEN_W'($urandom_range(0, 16'hFFFF));
			query  = $urandom;
			if (info == '0)
				info = 32'd1;
			if (packet == '0)
				packet = 32'd1;
			newest = sb.next_id - 1;
			if (roll < 45) begin
				op = OP_REGISTER;
				if (roll < 3)
					info = '0;
				else if (roll < 6)
					packet = '0;
			end else if (roll < 95) begin
				op   = (roll < 70) ? OP_RETRIEVE : OP_GET;
				pick = $urandom_range(9);
				// recent ids mostly hit, older ones may be evicted or taken
				if (pick < 6)
					query = newest - $urandom_range(0, 40);
				else if (pick < 8)
					query = newest - $urandom_range(0, 600);
				else if (pick == 8)
					query = newest - $urandom_range(0, 40) + SLOTS;
				else if ($urandom_range(1) == 0)
					query = '0;
				if (query > ID_LAST)
					query = $urandom_range(1, 8);
			end else begin
				op = OP_UNUSED;
			end
			send_request(op, query, info, packet, length);
		end
		calm_stretch = 1'b0;
		s_tvalid <= 1'b0;

		// let the owed replies come back, then wait on for late or stray beats
		@(posedge clk);
		while (sb.pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_replies.size() != 0)
			$error("%0d replies never arrived", sb.pending_replies.size());
		if (sb.errors == 0 && sb.pending_replies.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
